@@ rtl/playfair_cipher_engine_macros.svh @@
// Assertion macros for the Playfair cipher engine.
`ifndef PLAYFAIR_CIPHER_ENGINE_MACROS_SVH
`define PLAYFAIR_CIPHER_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define PFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfc assertion failed");
`define PFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfc assertion failed");
`else
`define PFC_ASSERT_IMP(lbl, ante, cons)
`define PFC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/pfc_pkg.sv @@
// Shared types, codes and helper functions of the Playfair cipher engine.
package pfc_pkg;

  localparam int Side = 5;
  localparam int Cells = 25;
  localparam int Letters = 26;
  localparam logic [4:0] LtrX = 5'd23;
  localparam logic [4:0] LtrJ = 5'd9;
  localparam logic [4:0] LtrI = 5'd8;
  localparam int BufDepth = 4;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_KEY   = 3'd1,
    CMD_BUILD = 3'd2,
    CMD_TEXT  = 3'd3,
    CMD_END   = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_PLACE, OP_BUILD, OP_SET_PEND, OP_PAIR, OP_END_PAIR,
    OP_POS_A, OP_POS_B, OP_LATCH_PB, OP_SQ1, OP_SQ2, OP_LATCH_O2,
    OP_FEED1, OP_FEED2, OP_FLUSH, OP_MARK, OP_DRAIN
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_BUILD, S_POS_A, S_POS_B, S_LATCH_PB, S_SQ1, S_SQ2,
    S_LATCH_O2, S_FEED1, S_FEED2, S_FLUSH, S_MARK, S_DRAIN
  } state_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       is_letter;
    logic       pend_valid;
    logic       build_last;
    logic       drain_done;
  } dp_status_t;

  // {valid, index} with J merged into I
  function automatic logic [5:0] letter_of(input logic [7:0] c);
    logic [4:0] idx;
    logic       ok;
    idx = 5'd0;
    ok = 1'b0;
    if (c >= 8'd65 && c <= 8'd90) begin
      idx = 5'(c - 8'd65);
      ok = 1'b1;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      idx = 5'(c - 8'd97);
      ok = 1'b1;
    end
    if (idx == LtrJ) idx = LtrI;
    return {ok, idx};
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] base;
    base = 5'(pos_row(p) * 3'd5);
    return 3'(p - base);
  endfunction

  function automatic logic [2:0] step5(input logic [2:0] v, input logic dec);
    logic [2:0] r;
    if (dec) r = (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
    else r = (v >= 3'd4) ? 3'd0 : 3'(v + 3'd1);
    return r;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return 5'(r * 3'd5) + {2'b00, c};
  endfunction

endpackage

@@ rtl/pfc_datapath.sv @@
// Datapath: key square memories, pairing, cipher lookup, cleanup and result buffer.
`include "playfair_cipher_engine_macros.svh"
module pfc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_accept,
  input  logic [2:0]            in_cmd,
  input  logic [7:0]            in_byte,
  input  logic                  cfg_write,
  input  logic                  cfg_mode,
  input  pfc_pkg::ctrl_cmd_t    cmd,
  output pfc_pkg::dp_status_t   status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            out_letter,
  output logic                  out_has,
  output logic                  out_last
);
  import pfc_pkg::*;

  logic [4:0]  pos_mem [Letters];
  logic [4:0]  sq_mem  [Cells];
  logic [4:0]  pos_q, sq_q;
  logic [25:0] seen;
  logic [4:0]  fill;
  logic        mode;
  logic [2:0]  cmd_q;
  logic [4:0]  idx_q;
  logic        letter_q;
  logic        pend_v;
  logic [4:0]  pend;
  logic        held_v;
  logic [4:0]  held;
  logic [4:0]  prev;
  logic        first;
  logic [4:0]  a_reg, b_reg, pa, pb, o1, o2;
  logic [4:0]  bld;
  logic [5:0]  buf_ent [BufDepth];
  logic [2:0]  cnt, rd;

  logic        place_en;
  logic [4:0]  place_idx;
  logic        do_place;
  logic [4:0]  pos_addr, sq_addr;
  logic [2:0]  r1, c1, r2, c2;
  logic [4:0]  addr1, addr2;
  logic [4:0]  d;
  logic        filler;
  logic        out_free;
  logic [5:0]  dec_l;

  assign dec_l = letter_of(in_byte);
  assign r1 = pos_row(pa);
  assign c1 = pos_col(pa);
  assign r2 = pos_row(pb);
  assign c2 = pos_col(pb);

  always_comb begin
    if (r1 == r2) begin
      addr1 = cell_of(r1, step5(c1, mode));
      addr2 = cell_of(r2, step5(c2, mode));
    end else if (c1 == c2) begin
      addr1 = cell_of(step5(r1, mode), c1);
      addr2 = cell_of(step5(r2, mode), c2);
    end else begin
      addr1 = cell_of(r1, c2);
      addr2 = cell_of(r2, c1);
    end
  end

  always_comb begin
    place_en = 1'b0;
    place_idx = idx_q;
    if (cmd.op == OP_PLACE) begin
      place_en = letter_q;
    end else if (cmd.op == OP_BUILD) begin
      place_idx = bld;
      place_en = (bld != LtrJ);
    end
  end
  assign do_place = place_en && (fill < 5'(Cells)) && !seen[place_idx];

  assign pos_addr = (cmd.op == OP_POS_B) ? b_reg : a_reg;
  assign sq_addr = (cmd.op == OP_SQ2) ? addr2 : addr1;

  always_ff @(posedge clk) begin
    if (do_place) begin
      sq_mem[fill] <= place_idx;
      pos_mem[place_idx] <= fill;
    end
    pos_q <= pos_mem[pos_addr];
    sq_q <= sq_mem[sq_addr];
  end

  assign d = (cmd.op == OP_FEED1) ? o1 : o2;
  assign filler = (held == LtrX) && !first && (prev == d);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      fill <= '0;
      mode <= 1'b0;
      pend_v <= 1'b0;
      held_v <= 1'b0;
      prev <= '0;
      first <= 1'b1;
      bld <= '0;
      cnt <= '0;
      rd <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (do_place) begin
        seen[place_idx] <= 1'b1;
        fill <= fill + 5'd1;
      end
      if (cfg_write) begin
        mode <= cfg_mode;
        pend_v <= 1'b0;
        held_v <= 1'b0;
        prev <= '0;
        first <= 1'b1;
      end
      if (in_accept) begin
        cmd_q <= in_cmd;
        idx_q <= dec_l[4:0];
        letter_q <= dec_l[5];
        cnt <= '0;
        rd <= '0;
      end
      case (cmd.op)
        OP_CLEAR: begin
          seen <= '0;
          fill <= '0;
        end
        OP_BUILD: begin
          bld <= (bld == 5'(Letters - 1)) ? 5'd0 : bld + 5'd1;
        end
        OP_SET_PEND: begin
          pend_v <= 1'b1;
          pend <= idx_q;
        end
        OP_PAIR: begin
          a_reg <= pend;
          if (pend == idx_q) begin
            b_reg <= LtrX;
          end else begin
            b_reg <= idx_q;
            pend_v <= 1'b0;
          end
        end
        OP_END_PAIR: begin
          a_reg <= pend;
          b_reg <= LtrX;
          pend_v <= 1'b0;
        end
        OP_POS_B: pa <= pos_q;
        OP_LATCH_PB: pb <= pos_q;
        OP_SQ2: o1 <= sq_q;
        OP_LATCH_O2: o2 <= sq_q;
        OP_FEED1, OP_FEED2: begin
          if (!mode) begin
            buf_ent[cnt[1:0]] <= {1'b1, d};
            cnt <= cnt + 3'd1;
          end else begin
            if (held_v) begin
              if (!filler) begin
                buf_ent[cnt[1:0]] <= {1'b1, held};
                cnt <= cnt + 3'd1;
              end
              prev <= held;
              first <= 1'b0;
            end
            held_v <= 1'b1;
            held <= d;
          end
        end
        OP_FLUSH: begin
          if (held_v && held != LtrX) begin
            buf_ent[cnt[1:0]] <= {1'b1, held};
            cnt <= cnt + 3'd1;
          end
          pend_v <= 1'b0;
          held_v <= 1'b0;
          prev <= '0;
          first <= 1'b1;
        end
        OP_MARK: begin
          if (cnt == 3'd0) begin
            buf_ent[0] <= 6'd0;
            cnt <= 3'd1;
          end
        end
        OP_DRAIN: begin
          if (rd != cnt && out_free) begin
            out_valid <= 1'b1;
            out_has <= buf_ent[rd[1:0]][5];
            out_letter <= buf_ent[rd[1:0]][5] ?
                          7'd65 + {2'b00, buf_ent[rd[1:0]][4:0]} : 7'd0;
            out_last <= (cmd_q == CMD_END) && (rd == cnt - 3'd1);
            rd <= rd + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.cmd = cmd_q;
  assign status.is_letter = letter_q;
  assign status.pend_valid = pend_v;
  assign status.build_last = (bld == 5'(Letters - 1));
  assign status.drain_done = (rd == cnt);

  `PFC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= 3'(BufDepth))
  `PFC_ASSERT_IMP(a_rd_bound, 1'b1, rd <= cnt)
  `PFC_ASSERT_IMP(a_fill_bound, 1'b1, fill <= 5'(Cells))
endmodule

@@ rtl/pfc_ctrl.sv @@
// Controller state machine sequencing the datapath per accepted beat.
module pfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_accept,
  input  pfc_pkg::dp_status_t  status,
  output pfc_pkg::ctrl_cmd_t   cmd,
  output logic                 in_ready
);
  import pfc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_accept) state_next = S_DECODE;
      S_DECODE: begin
        case (status.cmd)
          CMD_BUILD: state_next = S_BUILD;
          CMD_TEXT: state_next = (status.is_letter && status.pend_valid) ? S_POS_A : S_IDLE;
          CMD_END: state_next = status.pend_valid ? S_POS_A : S_FLUSH;
          default: state_next = S_IDLE;
        endcase
      end
      S_BUILD: if (status.build_last) state_next = S_IDLE;
      S_POS_A: state_next = S_POS_B;
      S_POS_B: state_next = S_LATCH_PB;
      S_LATCH_PB: state_next = S_SQ1;
      S_SQ1: state_next = S_SQ2;
      S_SQ2: state_next = S_LATCH_O2;
      S_LATCH_O2: state_next = S_FEED1;
      S_FEED1: state_next = S_FEED2;
      S_FEED2: state_next = (status.cmd == CMD_END) ? S_FLUSH : S_DRAIN;
      S_FLUSH: state_next = S_MARK;
      S_MARK: state_next = S_DRAIN;
      S_DRAIN: if (status.drain_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state)
      S_DECODE: begin
        case (status.cmd)
          CMD_CLEAR: cmd.op = OP_CLEAR;
          CMD_KEY: cmd.op = OP_PLACE;
          CMD_TEXT: begin
            if (status.is_letter) cmd.op = status.pend_valid ? OP_PAIR : OP_SET_PEND;
          end
          CMD_END: if (status.pend_valid) cmd.op = OP_END_PAIR;
          default: cmd.op = OP_NONE;
        endcase
      end
      S_BUILD: cmd.op = OP_BUILD;
      S_POS_A: cmd.op = OP_POS_A;
      S_POS_B: cmd.op = OP_POS_B;
      S_LATCH_PB: cmd.op = OP_LATCH_PB;
      S_SQ1: cmd.op = OP_SQ1;
      S_SQ2: cmd.op = OP_SQ2;
      S_LATCH_O2: cmd.op = OP_LATCH_O2;
      S_FEED1: cmd.op = OP_FEED1;
      S_FEED2: cmd.op = OP_FEED2;
      S_FLUSH: cmd.op = OP_FLUSH;
      S_MARK: cmd.op = OP_MARK;
      S_DRAIN: cmd.op = OP_DRAIN;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !rst;
endmodule

@@ rtl/playfair_cipher_engine.sv @@
// Top level of the Playfair cipher engine: ports, controller and datapath.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata char_byte, s_tuser command
// m_*      out  m_tvalid/m_tready   m_tdata letter,has_letter; m_tlast last
// cfg_*    in   cfg_valid/cfg_ready cfg_data decode_mode
//
// Clear, key byte, unpaired text and unknown commands return to idle after
// decode; build tries one letter per cycle over the alphabet. A ciphered
// text pair, or end of text with an open pair, reads both positions, then
// both square cells, serially on the one read port of each memory, and
// feeds the results; end of text then flushes and marks. Reset is synchronous
// and clears control state; square memories stay undefined until written.
// A stalled m_tready holds the output register; beats wait until results drain.
module playfair_cipher_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic [2:0] s_tuser,   // [2:0] command
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] letter, [7] has_letter
  output logic       m_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import pfc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_accept;
  logic [6:0] out_letter;
  logic       out_has;

  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = !rst;
  assign m_tdata = {out_has, out_letter};

  pfc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_accept(in_accept),
    .status(status),
    .cmd(cmd),
    .in_ready(s_tready)
  );

  pfc_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .in_accept(in_accept),
    .in_cmd(s_tuser),
    .in_byte(s_tdata),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_mode(cfg_data),
    .cmd(cmd),
    .status(status),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_letter(out_letter),
    .out_has(out_has),
    .out_last(m_tlast)
  );
endmodule
